@@ rtl/q4k_pkg.sv @@
// shared types and constants for the q4_k block dequantizer
`timescale 1ns / 1ps

package q4k_pkg;

    // block layout
    localparam logic [7:0] BLOCK_LAST_OFFSET = 8'd143;
    localparam logic [7:0] QUANT_BASE        = 8'd16;
    localparam logic [7:0] SCALE_BASE        = 8'd4;
    localparam logic [7:0] LAST_ELEMENT      = 8'd255;

    // fp32 constants
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC00000;
    localparam logic [31:0] QUIET_BIT    = 32'h00400000;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_A,
        OP_RND_A,
        OP_MUL_B,
        OP_RND_B,
        OP_MUL_C,
        OP_RND_C,
        OP_ADD,
        OP_NORM,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   nib;
    } dp_cmd_t;

    typedef struct packed {
        logic quant_byte;
        logic norm_done;
    } dp_status_t;

endpackage

@@ rtl/q4k_ctrl.sv @@
// controller state machine: sequences the shared fp units for each nibble
`timescale 1ns / 1ps

module q4k_ctrl
    import q4k_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL_A = 10'b00_0000_0010,
        S_RND_A = 10'b00_0000_0100,
        S_MUL_B = 10'b00_0000_1000,
        S_RND_B = 10'b00_0001_0000,
        S_MUL_C = 10'b00_0010_0000,
        S_RND_C = 10'b00_0100_0000,
        S_ADD   = 10'b00_1000_0000,
        S_NORM  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   nib_reg, nib_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    // output register is free when empty or being transferred
    assign out_free = !valid_reg || !result_stall;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        nib_next   = nib_reg;
        valid_next = valid_reg;
        cmd.op     = OP_NONE;
        cmd.nib    = nib_reg;
        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (byte_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (status.quant_byte)
                    begin
                        nib_next   = 1'b0;
                        state_next = S_MUL_A;
                    end
                end
            end
            S_MUL_A:
            begin
                cmd.op     = OP_MUL_A;
                state_next = S_RND_A;
            end
            S_RND_A:
            begin
                cmd.op     = OP_RND_A;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.op     = OP_MUL_B;
                state_next = S_RND_B;
            end
            S_RND_B:
            begin
                cmd.op     = OP_RND_B;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.op     = OP_MUL_C;
                state_next = S_RND_C;
            end
            S_RND_C:
            begin
                cmd.op     = OP_RND_C;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op     = OP_ADD;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_NORM;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    if (nib_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nib_next   = 1'b1;
                        state_next = S_MUL_A;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nib_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nib_reg   <= nib_next;
            valid_reg <= valid_next;
        end
    end

    assign byte_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

endmodule

@@ rtl/q4k_dp.sv @@
// datapath: block header storage, shared fp32 multiply and subtract units
`timescale 1ns / 1ps

module q4k_dp
    import q4k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  byte_value,
    input  logic        block_start,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [7:0]  element_index,
    output logic [31:0] value_bits,
    output logic        last_of_block
);

    localparam logic [7:0] OFF_D_LO    = 8'd0;
    localparam logic [7:0] OFF_D_HI    = 8'd1;
    localparam logic [7:0] OFF_DMIN_LO = 8'd2;
    localparam logic [7:0] OFF_DMIN_HI = 8'd3;

    // fp16 to fp32, exact for every class
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [23:0] tmp;
        logic [31:0] r;
        e = h[14:10];
        m = h[9:0];
        p = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
            begin
                p = 4'(i);
            end
        end
        tmp = 24'(m) << (5'd23 - {1'b0, p});
        if (e == 5'd0)
        begin
            if (m == 10'd0)
            begin
                r = {h[15], 31'b0};
            end
            else
            begin
                r = {h[15], {4'b0, p} + 8'd103, tmp[22:0]};
            end
        end
        else if (e == 5'h1F)
        begin
            r = {h[15], 8'hFF, m, 13'b0};
        end
        else
        begin
            r = {h[15], {3'b0, e} + 8'd112, m, 13'b0};
        end
        return r;
    endfunction

    // round the product of an fp32 value and a small integer
    function automatic logic [31:0] mul_round(input logic [31:0] x, input logic [5:0] k,
                                              input logic [29:0] p);
        logic [2:0]  n;
        logic [29:0] kept;
        logic [29:0] low;
        logic [29:0] half_bit;
        logic        guard;
        logic        sticky;
        logic        up;
        logic [24:0] t;
        logic [7:0]  e;
        logic [31:0] r;
        n = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (p[23 + i])
            begin
                n = 3'(i);
            end
        end
        kept     = p >> n;
        low      = p & ((30'd1 << n) - 30'd1);
        half_bit = (30'd1 << n) >> 1;
        guard    = |(p & half_bit);
        sticky   = |(low & ~half_bit);
        up       = guard & (sticky | kept[0]);
        t        = {1'b0, kept[23:0]} + {24'b0, up};
        e        = x[30:23] + {5'b0, n} + {7'b0, t[24]};
        if (x[30:23] == 8'hFF)
        begin
            if (x[22:0] != 23'd0)
            begin
                r = x | QUIET_BIT;
            end
            else if (k == 6'd0)
            begin
                r = QNAN_DEFAULT;
            end
            else
            begin
                r = x;
            end
        end
        else if (x[30:23] == 8'd0 || k == 6'd0)
        begin
            r = {x[31], 31'b0};
        end
        else
        begin
            r = {x[31], e, t[24] ? 23'b0 : t[22:0]};
        end
        return r;
    endfunction

    // header and byte state
    logic [7:0]  offset_reg;
    logic [15:0] scale_half_reg;
    logic [15:0] min_half_reg;
    logic [5:0]  sc_reg [8];
    logic [5:0]  mn_reg [8];
    logic [7:0]  byte_reg;
    logic [6:0]  quant_idx_reg;
    logic [7:0]  cur_offset;
    logic [3:0]  hdr_idx;

    // fp working registers
    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] mx_reg;
    logic [5:0]  k_reg;
    logic [29:0] prod_reg;
    logic        spec_reg;
    logic [31:0] spec_val_reg;
    logic [26:0] mant_reg;
    logic [7:0]  exp_reg;
    logic        sign_reg;
    logic [31:0] value_bits_reg;
    logic [7:0]  element_index_reg;
    logic        last_reg;

    logic [31:0] d_single, dm_single;
    logic [2:0]  grp;
    logic [5:0]  sc_sel, mn_sel;
    logic [3:0]  q_sel;
    logic [31:0] mul_x;
    logic [5:0]  mul_k;
    logic [29:0] mul_p;
    logic [31:0] mul_res;
    logic [7:0]  elem_idx;

    // offset of the byte on the input port
    assign cur_offset = (block_start || offset_reg > BLOCK_LAST_OFFSET) ? 8'd0 : offset_reg;
    assign hdr_idx    = 4'(cur_offset - SCALE_BASE);
    assign status.quant_byte = (cur_offset >= QUANT_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            offset_reg <= (cur_offset == BLOCK_LAST_OFFSET) ? 8'd0 : cur_offset + 8'd1;
        end
    end

    // header capture, scale and min unpacked per group as bytes arrive
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            byte_reg      <= byte_value;
            quant_idx_reg <= 7'(cur_offset - QUANT_BASE);
            if (cur_offset == OFF_D_LO)
            begin
                scale_half_reg[7:0] <= byte_value;
            end
            else if (cur_offset == OFF_D_HI)
            begin
                scale_half_reg[15:8] <= byte_value;
            end
            else if (cur_offset == OFF_DMIN_LO)
            begin
                min_half_reg[7:0] <= byte_value;
            end
            else if (cur_offset == OFF_DMIN_HI)
            begin
                min_half_reg[15:8] <= byte_value;
            end
            else if (cur_offset < QUANT_BASE)
            begin
                case (hdr_idx[3:2])
                    2'b00:
                    begin
                        sc_reg[{1'b0, hdr_idx[1:0]}]      <= byte_value[5:0];
                        sc_reg[{1'b1, hdr_idx[1:0]}][5:4] <= byte_value[7:6];
                    end
                    2'b01:
                    begin
                        mn_reg[{1'b0, hdr_idx[1:0]}]      <= byte_value[5:0];
                        mn_reg[{1'b1, hdr_idx[1:0]}][5:4] <= byte_value[7:6];
                    end
                    2'b10:
                    begin
                        sc_reg[{1'b1, hdr_idx[1:0]}][3:0] <= byte_value[3:0];
                        mn_reg[{1'b1, hdr_idx[1:0]}][3:0] <= byte_value[7:4];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // operand selection for the shared multiplier
    assign d_single  = half_to_single(scale_half_reg);
    assign dm_single = half_to_single(min_half_reg);
    assign grp       = {quant_idx_reg[6:5], cmd.nib};
    assign sc_sel    = sc_reg[grp];
    assign mn_sel    = mn_reg[grp];
    assign q_sel     = cmd.nib ? byte_reg[7:4] : byte_reg[3:0];

    always_comb
    begin
        mul_x = d_single;
        mul_k = sc_sel;
        case (cmd.op)
            OP_MUL_B:
            begin
                mul_x = a_reg;
                mul_k = {2'b0, q_sel};
            end
            OP_MUL_C:
            begin
                mul_x = dm_single;
                mul_k = mn_sel;
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p   = 30'({1'b1, mul_x[22:0]}) * 30'(mul_k);
    assign mul_res = mul_round(mx_reg, k_reg, prod_reg);

    // multiplier product register and rounded results
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL_A, OP_MUL_B, OP_MUL_C:
            begin
                prod_reg <= mul_p;
                mx_reg   <= mul_x;
                k_reg    <= mul_k;
            end
            OP_RND_A:
            begin
                a_reg <= mul_res;
            end
            OP_RND_B:
            begin
                b_reg <= mul_res;
            end
            OP_RND_C:
            begin
                c_reg <= mul_res;
            end
            default:
            begin
            end
        endcase
    end

    // subtract b - c: specials, alignment and add or subtract
    logic [31:0] y;
    logic        b_nan, c_nan, b_inf, c_inf, b_zero, c_zero;
    logic        swap, eff_sub;
    logic [31:0] big, sml;
    logic [7:0]  dexp;
    logic [26:0] bm, sm, sh, sm_al;
    logic [27:0] sum;
    logic [26:0] diff;
    logic        add_spec;
    logic [31:0] add_spec_val;
    logic [26:0] add_mant;
    logic [7:0]  add_exp;

    assign y       = {~c_reg[31], c_reg[30:0]};
    assign b_nan   = (b_reg[30:23] == 8'hFF) && (b_reg[22:0] != 23'd0);
    assign c_nan   = (c_reg[30:23] == 8'hFF) && (c_reg[22:0] != 23'd0);
    assign b_inf   = (b_reg[30:23] == 8'hFF) && (b_reg[22:0] == 23'd0);
    assign c_inf   = (c_reg[30:23] == 8'hFF) && (c_reg[22:0] == 23'd0);
    assign b_zero  = (b_reg[30:0] == 31'd0);
    assign c_zero  = (c_reg[30:0] == 31'd0);
    assign swap    = (c_reg[30:0] > b_reg[30:0]);
    assign big     = swap ? y : b_reg;
    assign sml     = swap ? b_reg : y;
    assign eff_sub = b_reg[31] ^ y[31];
    assign dexp    = big[30:23] - sml[30:23];
    assign bm      = {1'b1, big[22:0], 3'b0};
    assign sm      = {1'b1, sml[22:0], 3'b0};
    assign sh      = sm >> dexp;
    assign sm_al   = (dexp >= 8'd27) ? 27'd1 : (sh | {26'b0, (sh << dexp) != sm});
    assign sum     = {1'b0, bm} + {1'b0, sm_al};
    assign diff    = bm - sm_al;

    always_comb
    begin
        add_spec     = 1'b1;
        add_spec_val = 32'd0;
        add_mant     = sum[26:0];
        add_exp      = big[30:23];
        if (b_nan)
        begin
            add_spec_val = b_reg | QUIET_BIT;
        end
        else if (c_nan)
        begin
            add_spec_val = c_reg | QUIET_BIT;
        end
        else if (b_inf && c_inf)
        begin
            add_spec_val = (b_reg[31] == c_reg[31]) ? QNAN_DEFAULT : b_reg;
        end
        else if (b_inf)
        begin
            add_spec_val = b_reg;
        end
        else if (c_inf)
        begin
            add_spec_val = y;
        end
        else if (b_zero && c_zero)
        begin
            add_spec_val = {b_reg[31] & y[31], 31'b0};
        end
        else if (b_zero)
        begin
            add_spec_val = y;
        end
        else if (c_zero)
        begin
            add_spec_val = b_reg;
        end
        else if (eff_sub)
        begin
            // exact cancellation gives +0
            add_spec = (diff == 27'd0);
            add_mant = diff;
        end
        else
        begin
            add_spec = 1'b0;
            if (sum[27])
            begin
                add_mant = {sum[27:2], sum[1] | sum[0]};
                add_exp  = big[30:23] + 8'd1;
            end
        end
    end

    // final rounding of the normalized difference
    logic [23:0] r_keep;
    logic        r_up;
    logic [24:0] r_t;
    logic [31:0] r_val;

    assign r_keep = mant_reg[26:3];
    assign r_up   = mant_reg[2] & ((|mant_reg[1:0]) | r_keep[0]);
    assign r_t    = {1'b0, r_keep} + {24'b0, r_up};
    assign r_val  = spec_reg ? spec_val_reg
                  : {sign_reg, exp_reg + {7'b0, r_t[24]}, r_t[24] ? 23'b0 : r_t[22:0]};
    assign elem_idx = {quant_idx_reg[6:5], cmd.nib, quant_idx_reg[4:0]};

    // adder result, one-bit normalization steps and output register
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ADD:
            begin
                spec_reg     <= add_spec;
                spec_val_reg <= add_spec_val;
                mant_reg     <= add_mant;
                exp_reg      <= add_exp;
                sign_reg     <= big[31];
            end
            OP_NORM:
            begin
                mant_reg <= {mant_reg[25:0], 1'b0};
                exp_reg  <= exp_reg - 8'd1;
            end
            OP_OUT:
            begin
                value_bits_reg    <= r_val;
                element_index_reg <= elem_idx;
                last_reg          <= (elem_idx == LAST_ELEMENT);
            end
            default:
            begin
            end
        endcase
    end

    assign status.norm_done = spec_reg | mant_reg[26];
    assign element_index    = element_index_reg;
    assign value_bits       = value_bits_reg;
    assign last_of_block    = last_reg;

endmodule

@@ rtl/q4k_block_dequantizer.sv @@
// top level of the q4_k block dequantizer
//
//   channel   direction   handshake                      payload
//   byte      in          byte_valid / byte_stall        byte_value, block_start
//   result    out         result_valid / result_stall    element_index, value_bits,
//                                                        last_of_block
//
// header bytes (offsets 0..15) are loaded into the header registers and give no result.
// a quant byte is loaded and gives two results, each through the shared
// multiply and subtract units and one normalization step per left shift when
// the subtraction cancels leading bits (0..24); no byte is taken until both are made.
// rst_n clears the byte offset and the controller; header values are kept
// only once written. a full result register held by result_stall delays
// only the next result; the finished result waits in its register.
`timescale 1ns / 1ps

module q4k_block_dequantizer
    import q4k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_value,
    input  logic        block_start,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  element_index,
    output logic [31:0] value_bits,
    output logic        last_of_block
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller
    q4k_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath
    q4k_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_value    (byte_value),
        .block_start   (block_start),
        .cmd           (cmd),
        .status        (status),
        .element_index (element_index),
        .value_bits    (value_bits),
        .last_of_block (last_of_block)
    );

endmodule

@@ rtl/q4k_checker.sv @@
// port-level assertions for the q4_k block dequantizer, bound to the top level
`timescale 1ns / 1ps

module q4k_checker
    import q4k_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [7:0]  element_index,
    input logic [31:0] value_bits,
    input logic        last_of_block
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(value_bits) && $stable(element_index))
        else $error("result payload changed while stalled");

    // end of block flag marks exactly the last element
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last_of_block == (element_index == LAST_ELEMENT)))
        else $error("last_of_block does not match element index");

    // while a low-nibble result is pending the high nibble is still in work
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !element_index[5] |-> byte_stall)
        else $error("byte taken before its second result was made");

endmodule

bind q4k_block_dequantizer q4k_checker u_checker (.*);

@@ tb/tb_top.sv @@
// self-checking bench for the q4_k block dequantizer with a bit-exact fp32 predictor
`timescale 1ns / 1ps

module tb_top;
    import q4k_pkg::*;

    // one decoded element as it should leave the block
    typedef struct {
        logic [7:0]  idx;
        logic [31:0] bits;
        logic        last;
    } element_t;

    // predictor of the dequantizer plus the queue of elements still owed
    class dequant_predictor;
        logic [7:0]  offset;
        logic [15:0] d_half;
        logic [15:0] dmin_half;
        logic [7:0]  scale_bytes [12];
        element_t    pending_elements [$];

        function new();
            offset = 8'd0;
            d_half = 16'h0;
            dmin_half = 16'h0;
            foreach (scale_bytes[i]) scale_bytes[i] = 8'h0;
        endfunction

        // round m * 2^e to fp32, nearest even, with subnormals and overflow
        function logic [31:0] round_to_single(logic s, int e, logic [63:0] m);
            int p;
            int sh;
            int be;
            logic [63:0] mant;
            logic g;
            logic st;
            p = 63;
            while (!m[p]) p--;
            sh = p - 23;
            if (-149 - e > sh) sh = -149 - e;
            if (sh <= 0) begin
                mant = m << (-sh);
                g = 1'b0;
                st = 1'b0;
            end
            else if (sh >= 64) begin
                mant = 64'd0;
                g = (sh == 64) ? m[63] : 1'b0;
                st = (sh == 64) ? |(m & 64'h7FFF_FFFF_FFFF_FFFF) : 1'b1;
            end
            else begin
                mant = m >> sh;
                g = m[sh-1];
                st = (sh >= 2) ? |(m & ((64'd1 << (sh - 1)) - 64'd1)) : 1'b0;
            end
            if (g && (st || mant[0])) mant = mant + 64'd1;
            if (mant[24]) begin
                mant = mant >> 1;
                sh++;
            end
            be = e + sh + 150;
            if (mant[23]) begin
                if (be >= 255) return {s, 8'hFF, 23'h0};
                return {s, be[7:0], mant[22:0]};
            end
            return {s, 8'h00, mant[22:0]};
        endfunction

        function void split_single(logic [31:0] x, output logic [63:0] m, output int e);
            if (x[30:23] == 8'h00) begin
                m = {41'd0, x[22:0]};
                e = -149;
            end
            else begin
                m = {40'd0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        function logic is_nan(logic [31:0] x);
            return (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
        endfunction

        function logic is_inf(logic [31:0] x);
            return (x[30:23] == 8'hFF) && (x[22:0] == 23'h0);
        endfunction

        function logic is_zero(logic [31:0] x);
            return x[30:0] == 31'h0;
        endfunction

        function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
            logic [63:0] ma;
            logic [63:0] mb;
            int ea;
            int eb;
            logic s;
            s = a[31] ^ b[31];
            if (is_nan(a)) return a | QUIET_BIT;
            if (is_nan(b)) return b | QUIET_BIT;
            if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return QNAN_DEFAULT;
            if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'h0};
            if (is_zero(a) || is_zero(b)) return {s, 31'h0};
            split_single(a, ma, ea);
            split_single(b, mb, eb);
            return round_to_single(s, ea + eb, ma * mb);
        endfunction

        // a - b
        function logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] big;
            logic [63:0] lil;
            logic [63:0] m;
            logic [63:0] tm;
            int ea;
            int eb;
            int te;
            int e;
            logic sa;
            logic sb;
            logic ts;
            logic s;
            sa = a[31];
            sb = ~b[31];
            if (is_nan(a)) return a | QUIET_BIT;
            if (is_nan(b)) return b | QUIET_BIT;
            if (is_inf(a) && is_inf(b)) return (sa == sb) ? {sa, 8'hFF, 23'h0} : QNAN_DEFAULT;
            if (is_inf(a)) return {sa, 8'hFF, 23'h0};
            if (is_inf(b)) return {sb, 8'hFF, 23'h0};
            if (is_zero(a) && is_zero(b)) return {sa & sb, 31'h0};
            split_single(a, ma, ea);
            split_single(b, mb, eb);
            if (eb > ea) begin
                tm = ma; ma = mb; mb = tm;
                te = ea; ea = eb; eb = te;
                ts = sa; sa = sb; sb = ts;
            end
            if (ea - eb > 40) begin
                // far smaller operand only matters as a sticky bit
                big = ma << 40;
                lil = (mb != 64'd0) ? 64'd1 : 64'd0;
                e = ea - 40;
            end
            else begin
                big = ma << (ea - eb);
                lil = mb;
                e = eb;
            end
            if (sa == sb) begin
                m = big + lil;
                s = sa;
            end
            else if (big >= lil) begin
                m = big - lil;
                s = sa;
            end
            else begin
                m = lil - big;
                s = sb;
            end
            if (m == 64'd0) return 32'h0;
            return round_to_single(s, e, m);
        endfunction

        function logic [31:0] small_int_to_single(logic [5:0] v);
            if (v == 6'd0) return 32'h0;
            return round_to_single(1'b0, 0, {58'd0, v});
        endfunction

        function logic [31:0] widen_half(logic [15:0] h);
            logic [31:0] sgn;
            sgn = {h[15], 31'h0};
            if (h[14:10] == 5'd0) begin
                if (h[9:0] == 10'd0) return sgn;
                return round_to_single(h[15], -24, {54'd0, h[9:0]});
            end
            if (h[14:10] == 5'd31) return sgn | 32'h7F800000 | {9'd0, h[9:0], 13'd0};
            return sgn | {1'b0, 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
        endfunction

        function logic [31:0] element_value(int g, logic [3:0] q);
            logic [5:0] sc;
            logic [5:0] mn;
            logic [31:0] prod;
            if (g < 4) begin
                sc = scale_bytes[g][5:0];
                mn = scale_bytes[g+4][5:0];
            end
            else begin
                sc = {scale_bytes[g-4][7:6], scale_bytes[g+4][3:0]};
                mn = {scale_bytes[g][7:6], scale_bytes[g+4][7:4]};
            end
            prod = fmul(fmul(widen_half(d_half), small_int_to_single(sc)),
                        small_int_to_single({2'b00, q}));
            return fsub(prod, fmul(widen_half(dmin_half), small_int_to_single(mn)));
        endfunction

        // one accepted byte transfer
        function void take_byte(logic [7:0] v, logic start);
            int j;
            int pair;
            element_t lo;
            element_t hi;
            if (start || offset > BLOCK_LAST_OFFSET) offset = 8'd0;
            if (offset == 8'd0) d_half[7:0] = v;
            else if (offset == 8'd1) d_half[15:8] = v;
            else if (offset == 8'd2) dmin_half[7:0] = v;
            else if (offset == 8'd3) dmin_half[15:8] = v;
            else if (offset < QUANT_BASE) scale_bytes[offset - SCALE_BASE] = v;
            else begin
                j = int'(offset - QUANT_BASE);
                pair = j / 32;
                lo.idx = 8'(pair * 64 + j % 32);
                lo.bits = element_value(2 * pair, v[3:0]);
                lo.last = 1'b0;
                hi.idx = lo.idx + 8'd32;
                hi.bits = element_value(2 * pair + 1, v[7:4]);
                hi.last = (hi.idx == LAST_ELEMENT);
                pending_elements.push_back(lo);
                pending_elements.push_back(hi);
            end
            offset = (offset >= BLOCK_LAST_OFFSET) ? 8'd0 : offset + 8'd1;
        endfunction

        // returns an empty string on a match
        function string check_element(logic [7:0] idx, logic [31:0] bits, logic last);
            element_t exp_e;
            if (pending_elements.size() == 0)
                return $sformatf("unexpected element idx=%0d bits=%08h", idx, bits);
            exp_e = pending_elements.pop_front();
            if (idx !== exp_e.idx || bits !== exp_e.bits || last !== exp_e.last)
                return $sformatf("element got idx=%0d bits=%08h last=%0b want idx=%0d bits=%08h last=%0b",
                                 idx, bits, last, exp_e.idx, exp_e.bits, exp_e.last);
            return "";
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  byte_value;
    logic        block_start;
    logic        result_valid;
    logic        result_stall;
    logic [7:0]  element_index;
    logic [31:0] value_bits;
    logic        last_of_block;

    dequant_predictor pred;
    int errors;
    int bytes_sent;
    bit calm;
    bit pressure_done;
    int stall_left;

    q4k_block_dequantizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .block_start   (block_start),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .element_index (element_index),
        .value_bits    (value_bits),
        .last_of_block (last_of_block)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one byte transfer, held until accepted
    task automatic send_byte(logic [7:0] v, logic start);
        @(negedge clk);
        byte_valid = 1'b1;
        byte_value = v;
        block_start = start;
        do @(posedge clk); while (byte_stall);
        pred.take_byte(v, start);
        bytes_sent++;
    endtask

    task automatic sender_idle(int n);
        if (n > 0)
        begin
            @(negedge clk);
            byte_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7C00;
            3: return 16'hFC00;
            4: return 16'h7E01 | 16'($urandom_range(0, 1) << 15);
            5: return 16'h7C01;
            6: return 16'($urandom_range(1, 1023));
            7: return 16'h7BFF | 16'($urandom_range(0, 1) << 15);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // one well-formed block with random content, cut short when count < 144
    task automatic send_block(int count);
        logic [15:0] dh;
        logic [15:0] mh;
        logic [7:0]  v;
        logic        st;
        dh = pick_half();
        mh = pick_half();
        for (int k = 0; k < count; k++)
        begin
            if (k == 0) v = dh[7:0];
            else if (k == 1) v = dh[15:8];
            else if (k == 2) v = mh[7:0];
            else if (k == 3) v = mh[15:8];
            else v = 8'($urandom_range(0, 255));
            st = (k == 0) ? 1'($urandom_range(0, 3) != 0) : 1'b0;
            send_byte(v, st);
            sender_idle(pick_gap());
        end
    endtask

    // receiver: stall pattern, changed at the falling edge
    initial
    begin
        result_stall = 1'b0;
        stall_left = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && bytes_sent >= 400)
            begin
                // long hold-off so the block fills and stalls its input
                pressure_done = 1'b1;
                stall_left = 3000;
            end
            if (stall_left > 0)
            begin
                result_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall = 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // result transfers
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && result_valid && !result_stall)
        begin
            msg = pred.check_element(element_index, value_bits, last_of_block);
            if (msg != "") report(msg);
        end
    end

    // run limit
    initial
    begin
        #4000000;
        $display("FAIL q4k_block_dequantizer");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [7:0] directed [22];
        errors = 0;
        bytes_sent = 0;
        calm = 1'b0;
        pred = new();
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_value = 8'h00;
        block_start = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed block: d = 1.0, dmin = 0.5, scale bytes at extremes, then restart
        directed = '{8'h00, 8'h3C, 8'h00, 8'h38,
                     8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h3F, 8'hC0,
                     8'hF0, 8'h0F, 8'hFF, 8'h00,
                     8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h5A, 8'hA5};
        foreach (directed[i]) send_byte(directed[i], i == 0);
        send_byte(8'hFF, 1'b1);

        // random: mostly full blocks, some cut short by an early restart
        while (bytes_sent < 1200)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) send_block($urandom_range(1, 143));
            else send_block(144);
        end
        @(negedge clk);
        byte_valid = 1'b0;

        // drain
        while (pred.pending_elements.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS q4k_block_dequantizer");
        else
            $display("FAIL q4k_block_dequantizer");
        $finish;
    end

endmodule
